FILE: hdl/cht_pkg.sv
// shared types, field widths and result codes of the chained hash table
`timescale 1ns / 1ps

package cht_pkg;

	localparam int KEY_W    = 31;
	localparam int VAL_W    = 64;
	localparam int STATUS_W = 3;
	localparam int BIDX_W   = 4;
	localparam int CFG_W    = 5;

	// bucket count after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// remainder unit: key bits retired per cycle
	localparam int DIGIT_W   = 8;
	localparam int MOD_STEPS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W     = MOD_STEPS * DIGIT_W;

	// request types
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// result codes
	localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    out_value;
		logic [BIDX_W-1:0]   bucket_index;
	} rsp_t;

endpackage

FILE: hdl/cht_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/cht_mod_unit.sv
// iterative key remainder unit, one digit of the key per cycle
`timescale 1ns / 1ps

module cht_mod_unit import cht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [CFG_W-1:0] divisor,
	output logic             done,
	output logic [CFG_W-1:0] rem
);

	localparam int CW = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [PAD_W-1:0] shreg_q;
	logic [CFG_W-1:0] div_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] rem_nxt;

	// restoring remainder steps over one digit, most significant bit first
	always_comb begin
		logic [CFG_W-1:0]   r;
		logic [CFG_W:0]     t;
		logic [DIGIT_W-1:0] digit;
		r     = rem_q;
		digit = shreg_q[PAD_W-1 -: DIGIT_W];
		for (int j = 0; j < DIGIT_W; j++) begin
			t = {r, digit[DIGIT_W-1-j]};
			if (t >= {1'b0, div_q}) begin
				r = CFG_W'(t - {1'b0, div_q});
			end else begin
				r = t[CFG_W-1:0];
			end
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= PAD_W'(dividend);
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shreg_q <= shreg_q << DIGIT_W;
			rem_q   <= rem_nxt;
		end
	end

	assign done = busy_q && (cnt_q == CW'(MOD_STEPS - 1));
	assign rem  = rem_nxt;

endmodule

FILE: hdl/cht_chain_match.sv
// registered key compare across one bucket's chain row
`timescale 1ns / 1ps

module cht_chain_match import cht_pkg::*; #(
	parameter int CHAIN_DEPTH = 8,
	localparam int FW = $clog2(CHAIN_DEPTH + 1),
	localparam int SW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         capture,
	input  logic [CHAIN_DEPTH*KEY_W-1:0] row_keys,
	input  logic [FW-1:0]                fill,
	input  logic [KEY_W-1:0]             key,
	output logic                         hit,
	output logic [SW-1:0]                slot
);

	logic [CHAIN_DEPTH-1:0] match;
	logic                   hit_d;
	logic [SW-1:0]          slot_d;
	logic                   hit_q;
	logic [SW-1:0]          slot_q;

	always_comb begin
		for (int i = 0; i < CHAIN_DEPTH; i++) begin
			match[i] = (FW'(i) < fill) && (row_keys[i*KEY_W +: KEY_W] == key);
		end
	end

	// lowest matching slot wins
	always_comb begin
		hit_d  = |match;
		slot_d = '0;
		for (int i = CHAIN_DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				slot_d = SW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (capture) begin
			hit_q <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			slot_q <= slot_d;
		end
	end

	assign hit  = hit_q;
	assign slot = slot_q;

endmodule

FILE: hdl/chained_hash_table.sv
// chained hash table top level: request sequencer, row and value memories
`timescale 1ns / 1ps

// Keyed store of BUCKETS buckets, each a chain of up to CHAIN_DEPTH key and
// value entries. A request's bucket is key modulo the bucket count register
// (0 acts as 1, anything above BUCKETS acts as BUCKETS). An insert updates
// the value of a key already in its bucket, else appends it, else reports
// bucket full. A search returns the stored value or not found. Each request
// gives exactly one response transaction; bucket_index carries the low four
// bits of the bucket. Requests are handled one at a time: remainder unit (8
// key bits a cycle), row memory read, registered chain compare, update
// state and, for a search hit, value memory read precede the response
// register; the next request is accepted in the cycle after. A waiting
// response stalls the sequencer only once the next request has finished.
// After reset a clearing pass over all BUCKETS rows zeroes the chain fill
// counts before the first request is taken. The user must write the bucket
// count register only while idle; the block does not enforce it.
module chained_hash_table import cht_pkg::*; #(
	parameter int BUCKETS     = 16,
	parameter int CHAIN_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// bucket count register
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	// request channel
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req_data,
	// response channel
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp_data
);

	// row layout: chain keys above, fill count in the low bits
	localparam int FW    = $clog2(CHAIN_DEPTH + 1);
	localparam int SW    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int ROW_W = FW + CHAIN_DEPTH * KEY_W;
	localparam int VDEPTH = BUCKETS * CHAIN_DEPTH;
	localparam int VAW   = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
	localparam logic [CFG_W-1:0] DIV_MAX = CFG_W'((BUCKETS > 31) ? 31 : BUCKETS);

	// sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_ACT  = 3'd4;
	localparam logic [2:0] S_VRD  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]          state_q;
	logic [BW-1:0]       clr_q;
	logic [CFG_W-1:0]    cfg_q;
	logic [CFG_W-1:0]    eff_div;
	req_t                req_q;
	logic [CFG_W-1:0]    bkt_q;
	logic [BW+CFG_W-1:0] bkt_ext;
	logic [BW+CFG_W-1:0] rem_ext;
	logic [BW-1:0]       bkt_addr;
	logic [BW-1:0]       rem_addr;
	logic [STATUS_W-1:0] res_status_q;
	logic [VAL_W-1:0]    res_value_q;
	logic                rsp_valid_q;
	rsp_t                rsp_data_q;
	logic                rsp_load;

	logic                accept;
	logic                mod_done;
	logic [CFG_W-1:0]    mod_rem;

	// row memory ports
	logic                row_we;
	logic [BW-1:0]       row_waddr;
	logic [ROW_W-1:0]    row_wdata;
	logic                row_re;
	logic [ROW_W-1:0]    row_rd;
	logic [ROW_W-1:0]    row_new;
	logic [FW-1:0]       row_fill;

	// value memory ports
	logic                val_we;
	logic                val_re;
	logic [VAW-1:0]      val_addr;
	logic [VAL_W-1:0]    val_rd;
	logic [SW-1:0]       val_slot;

	logic                hit;
	logic [SW-1:0]       hit_slot;
	logic                is_full;

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);

	// finished result enters the response register once it is free or leaving
	assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	// clamp the register to a usable divisor
	always_comb begin
		if (cfg_q == '0) begin
			eff_div = CFG_W'(1);
		end else if (cfg_q > DIV_MAX) begin
			eff_div = DIV_MAX;
		end else begin
			eff_div = cfg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	cht_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (req_data.key),
		.divisor  (eff_div),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// bucket number to memory row; remainder is always below BUCKETS
	assign rem_ext  = {BW'(0), mod_rem};
	assign rem_addr = rem_ext[BW-1:0];
	assign bkt_ext  = {BW'(0), bkt_q};
	assign bkt_addr = bkt_ext[BW-1:0];

	assign row_fill = row_rd[FW-1:0];
	assign is_full  = (row_fill >= FW'(CHAIN_DEPTH));

	// appended row: new key in the first free slot, fill count bumped
	always_comb begin
		row_new         = row_rd;
		row_new[FW-1:0] = row_fill + FW'(1);
		for (int i = 0; i < CHAIN_DEPTH; i++) begin
			if (row_fill == FW'(i)) begin
				row_new[FW + i*KEY_W +: KEY_W] = req_q.key;
			end
		end
	end

	// row memory: clearing pass after reset, appends in the update cycle
	always_comb begin
		row_we    = 1'b0;
		row_waddr = bkt_addr;
		row_wdata = row_new;
		case (state_q)
			S_CLR: begin
				row_we    = 1'b1;
				row_waddr = clr_q;
				row_wdata = '0;
			end
			S_ACT: begin
				row_we = (req_q.req_type == REQ_INSERT) && !hit && !is_full;
			end
			default: begin
				row_we = 1'b0;
			end
		endcase
	end

	assign row_re = (state_q == S_DIV) && mod_done;

	cht_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (row_we),
		.wr_addr (row_waddr),
		.wr_data (row_wdata),
		.rd_en   (row_re),
		.rd_addr (rem_addr),
		.rd_data (row_rd)
	);

	cht_chain_match #(
		.CHAIN_DEPTH (CHAIN_DEPTH)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.capture  (state_q == S_CMP),
		.row_keys (row_rd[ROW_W-1:FW]),
		.fill     (row_fill),
		.key      (req_q.key),
		.hit      (hit),
		.slot     (hit_slot)
	);

	// value slot: the matching entry, or the first free one on an append
	assign val_slot = hit ? hit_slot : row_fill[SW-1:0];
	assign val_addr = VAW'(bkt_addr) * VAW'(CHAIN_DEPTH) + VAW'(val_slot);
	assign val_we   = (state_q == S_ACT) && (req_q.req_type == REQ_INSERT) &&
	                  (hit || !is_full);
	assign val_re   = (state_q == S_ACT) && (req_q.req_type == REQ_SEARCH) && hit;

	cht_ram #(
		.WIDTH (VAL_W),
		.DEPTH (VDEPTH)
	) u_val_ram (
		.clk     (clk),
		.wr_en   (val_we),
		.wr_addr (val_addr),
		.wr_data (req_q.value),
		.rd_en   (val_re),
		.rd_addr (val_addr),
		.rd_data (val_rd)
	);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// response register drains independently of the sequencer
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (mod_done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					if (val_re) begin
						state_q <= S_VRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_VRD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request, bucket and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_data;
		end
		if ((state_q == S_DIV) && mod_done) begin
			bkt_q <= mod_rem;
		end
		if (state_q == S_ACT) begin
			res_value_q <= '0;
			if (req_q.req_type == REQ_SEARCH) begin
				res_status_q <= hit ? STATUS_FOUND : STATUS_NOT_FOUND;
			end else if (hit) begin
				res_status_q <= STATUS_UPDATED;
			end else if (is_full) begin
				res_status_q <= STATUS_FULL;
			end else begin
				res_status_q <= STATUS_INSERTED;
			end
		end
		if (state_q == S_VRD) begin
			res_value_q <= val_rd;
		end
		if (rsp_load) begin
			rsp_data_q.status       <= res_status_q;
			rsp_data_q.out_value    <= res_value_q;
			rsp_data_q.bucket_index <= bkt_q[BIDX_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// one request at a time: the channel closes right after a transaction
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request accepted while another is in flight");

	// a chain never holds more entries than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (row_fill <= FW'(CHAIN_DEPTH)))
		else $error("chain fill count beyond chain depth");

	// a finished result always reaches the response register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp_valid)
		else $error("finished result not presented");

	// only a successful search carries a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.status != STATUS_FOUND)) |-> (rsp_data.out_value == '0))
		else $error("non-zero value on a result other than found");

endmodule

FILE: verif/cht_checker.sv
// response checker for the chained hash table: predicts each response and compares it
`timescale 1ns / 1ps

module cht_checker import cht_pkg::*; #(
	parameter int BUCKETS     = 16,
	parameter int CHAIN_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req_data,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp_data,
	output int               mismatches,
	output int               outstanding
);

	logic [CFG_W-1:0] bucket_count;
	logic [KEY_W-1:0] chain_key [BUCKETS][CHAIN_DEPTH];
	logic [VAL_W-1:0] chain_val [BUCKETS][CHAIN_DEPTH];
	int unsigned      chain_len [BUCKETS];
	rsp_t             pending_rsp [$];
	int               fail_total;

	assign mismatches = fail_total;

	// applies one request to the shadow table and returns its response
	function automatic rsp_t hash_lookup_update(input req_t r);
		int unsigned div;
		int unsigned b;
		int unsigned slot;
		int unsigned i;
		bit          hit;
		rsp_t        res;
		div = (bucket_count == 0) ? 1 :
			((bucket_count > BUCKETS) ? BUCKETS : bucket_count);
		b    = r.key % div;
		hit  = 1'b0;
		slot = 0;
		for (i = 0; i < chain_len[b]; i++) begin
			if (!hit && chain_key[b][i] == r.key) begin
				hit  = 1'b1;
				slot = i;
			end
		end
		res.out_value    = '0;
		res.bucket_index = b[BIDX_W-1:0];
		if (r.req_type == REQ_SEARCH) begin
			if (hit) begin
				res.status    = STATUS_FOUND;
				res.out_value = chain_val[b][slot];
			end else begin
				res.status = STATUS_NOT_FOUND;
			end
		end else if (hit) begin
			chain_val[b][slot] = r.value;
			res.status = STATUS_UPDATED;
		end else if (chain_len[b] >= CHAIN_DEPTH) begin
			res.status = STATUS_FULL;
		end else begin
			chain_key[b][chain_len[b]] = r.key;
			chain_val[b][chain_len[b]] = r.value;
			chain_len[b]++;
			res.status = STATUS_INSERTED;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			bucket_count = CFG_RESET;
			foreach (chain_len[b])
				chain_len[b] = 0;
			pending_rsp.delete();
			fail_total  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				bucket_count = cfg_wdata;
			// responses first: a request accepted now cannot be answered at this edge
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: unexpected response status %0d value %h bucket %0d",
							$realtime, rsp_data.status, rsp_data.out_value,
							rsp_data.bucket_index);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp_data.status !== want.status ||
					    rsp_data.out_value !== want.out_value ||
					    rsp_data.bucket_index !== want.bucket_index) begin
						fail_total++;
						if (fail_total <= 10)
							$display("%0t: mismatch exp st %0d val %h bkt %0d, got st %0d val %h bkt %0d",
								$realtime, want.status, want.out_value, want.bucket_index,
								rsp_data.status, rsp_data.out_value, rsp_data.bucket_index);
					end
				end
			end
			if (req_valid && !req_stall)
				pending_rsp = {pending_rsp, hash_lookup_update(req_data)};
			outstanding <= pending_rsp.size();
		end
	end

endmodule

FILE: verif/chained_hash_table_tb.sv
// testbench top for the chained hash table: stimulus, flow control and verdict
`timescale 1ns / 1ps

module chained_hash_table_tb;
	import cht_pkg::*;

	localparam int BUCKETS     = 16;
	localparam int CHAIN_DEPTH = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 20;   // wait before the verdict
	localparam int LONG_HOLD   = 300;
	localparam int BLOCK_ITEMS = 150;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// bucket count per random block bar the eighth: extremes, out of range, odd sizes
	localparam logic [CFG_W-1:0] BUCKET_PLAN [9] =
		'{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd17, 5'd3, 5'd16, 5'd16};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = CFG_RESET;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req_data  = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp_data;

	int mismatches;
	int outstanding;

	// flow control knobs
	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_requests = 0;
	int holds_done    = 0;
	int hold_left     = 0;

	int unsigned      cycle_count = 0;
	logic [KEY_W-1:0] key_pool [$];

	chained_hash_table #(
		.BUCKETS    (BUCKETS),
		.CHAIN_DEPTH(CHAIN_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	cht_checker #(
		.BUCKETS    (BUCKETS),
		.CHAIN_DEPTH(CHAIN_DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: a run that hangs is a failure
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL chained_hash_table");
		$finish;
	end

	// response side back-pressure; a long hold is timed here, not by the sender
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (holds_done != hold_requests) begin
			holds_done <= hold_requests;
			hold_left  <= LONG_HOLD;
			rsp_stall  <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	function automatic req_t make_req(input logic kind, input logic [KEY_W-1:0] k,
	                                  input logic [VAL_W-1:0] v);
		req_t r;
		r.req_type = kind;
		r.key      = k;
		r.value    = v;
		return r;
	endfunction

	// offer one transaction, hold it until taken, then maybe go quiet for a while
	task automatic send_req(input req_t r);
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	// stop offering and wait until every predicted response has been seen
	task automatic drain;
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// bucket count write, only ever issued with the block idle
	task automatic write_buckets(input logic [CFG_W-1:0] count);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly keys already inserted or small keys, so hits, updates and full
	// buckets all turn up; the rest are wide random keys
	task automatic random_req(output req_t r);
		int pick;
		pick       = $urandom_range(99);
		r.req_type = ($urandom_range(99) < 45) ? REQ_INSERT : REQ_SEARCH;
		r.value    = {$urandom, $urandom};
		if (pick < 55 && key_pool.size() > 0)
			r.key = key_pool[$urandom_range(key_pool.size() - 1)];
		else if (pick < 80)
			r.key = KEY_W'($urandom_range(63));
		else
			r.key = KEY_W'($urandom);
		if (r.req_type == REQ_INSERT) begin
			if (key_pool.size() < 64)
				key_pool = {key_pool, r.key};
			else
				key_pool[$urandom_range(63)] = r.key;
		end
	endtask

	initial begin
		req_t             r;
		int               ph;
		int               blk;
		int               i;
		logic [CFG_W-1:0] count;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// phase one pacing: sender mostly busy, receiver mostly stalling
		send_idle_pct = 13;
		rcv_stall_pct <= 76;

		// directed transactions at the reset bucket count of sixteen
		send_req(make_req(REQ_INSERT, '0, '0));
		send_req(make_req(REQ_INSERT, KEY_MAX, VAL_MAX));
		send_req(make_req(REQ_SEARCH, '0, VAL_MAX));
		send_req(make_req(REQ_SEARCH, KEY_MAX, '0));
		// fill bucket three to the chain depth, then overflow it
		for (i = 0; i < CHAIN_DEPTH; i++)
			send_req(make_req(REQ_INSERT, KEY_W'(3 + 16 * i), 64'h1000 + i));
		send_req(make_req(REQ_INSERT, KEY_W'(3 + 16 * CHAIN_DEPTH), 64'hdead));
		// a key already present is still updated while its bucket is full
		send_req(make_req(REQ_INSERT, KEY_W'(19), 64'h0123_4567_89ab_cdef));
		send_req(make_req(REQ_SEARCH, KEY_W'(19), '0));
		send_req(make_req(REQ_SEARCH, KEY_W'(3 + 16 * CHAIN_DEPTH), '0));
		send_req(make_req(REQ_INSERT, '0, 64'd5));
		drain();

		// a count of zero behaves as one: every key lands in bucket zero, and
		// entries placed in other buckets under the old mapping are no longer reachable
		write_buckets(5'd0);
		send_req(make_req(REQ_SEARCH, '0, '0));
		send_req(make_req(REQ_SEARCH, KEY_W'(19), '0));
		send_req(make_req(REQ_INSERT, KEY_W'(19), 64'h77));
		drain();

		// above the number of buckets the mapping clamps back to sixteen
		write_buckets(5'd31);
		send_req(make_req(REQ_SEARCH, KEY_W'(19), '0));
		send_req(make_req(REQ_SEARCH, KEY_MAX, '0));
		drain();

		// random blocks, three pacing phases of three bucket settings each
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 13;
					rcv_stall_pct <= 76;
				end
				1: begin
					send_idle_pct = 76;
					rcv_stall_pct <= 13;
				end
				default: begin
					send_idle_pct = 0;
					rcv_stall_pct <= 0;
				end
			endcase
			for (blk = 0; blk < 3; blk++) begin
				count = (ph * 3 + blk == 7) ? CFG_W'($urandom_range(16, 1)) :
					BUCKET_PLAN[ph * 3 + blk];
				write_buckets(count);
				// long receiver hold while the sender keeps pushing, to back the block up
				if (ph == 2 && blk == 0)
					hold_requests <= hold_requests + 1;
				for (i = 0; i < BLOCK_ITEMS; i++) begin
					random_req(r);
					send_req(r);
				end
				drain();
			end
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS chained_hash_table");
		else
			$display("FAIL chained_hash_table");
		$finish;
	end

endmodule
